/* design/edq_pkg.sv */
// edq_pkg: shared constants for the edge-qualified input debouncer
// holds trigger mode codes, register indexes and reset values
// no dependencies
package edq_pkg;

    // trigger mode codes
    localparam logic [1:0] MODE_ANY  = 2'd0;
    localparam logic [1:0] MODE_RISE = 2'd1;
    localparam logic [1:0] MODE_FALL = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TRIGGER_MODE = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INVERT       = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FILTER_TICKS = 2'd2;

    // register widths and reset values
    localparam int unsigned CFG_DATA_BITS     = 16;
    localparam int unsigned FILTER_TICKS_BITS = 16;
    localparam logic [FILTER_TICKS_BITS-1:0] FILTER_TICKS_RESET = 16'd50;

endpackage

/* design/edge_debounce_input_qualifier_core.sv */
// edge_debounce_input_qualifier_core: one pin sample per item, edge-qualified debounce
// a result item is registered and is visible in the cycle after the item that causes it is accepted
// throughput: one item per cycle; all work sits between the input port and the result register
// in_ready drops only while a result waits and out_ready is low
// reset: asynchronous, active low; clears the countdown, edge history and the result register
// depends on edq_pkg
module edge_debounce_input_qualifier_core #(
    parameter int unsigned FILTER_COUNT_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // item input channel
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  pin_level,
    // result channel
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  reported_level,
    // configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [edq_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [edq_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    localparam logic [FILTER_COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [FILTER_COUNT_BITS-1:0] COUNT_ONE = FILTER_COUNT_BITS'(1);

    // configuration registers
    logic [1:0]                                trigger_mode_reg;
    logic                                      invert_reg;
    logic [edq_pkg::FILTER_TICKS_BITS-1:0]     filter_ticks_reg;

    // debounce state
    logic                                      previous_sample_reg;
    logic                                      captured_level_reg;
    logic [FILTER_COUNT_BITS-1:0]              filter_count_reg;
    logic                                      filter_armed_reg;

    // result register
    logic                                      out_valid_reg;
    logic                                      reported_level_reg;

    // next values
    logic                                      previous_sample_next;
    logic                                      captured_level_next;
    logic [FILTER_COUNT_BITS-1:0]              filter_count_next;
    logic                                      filter_armed_next;
    logic                                      out_valid_next;
    logic                                      reported_level_next;

    // combinational work
    logic                                      accept;
    logic                                      rise;
    logic                                      fall;
    logic                                      qualifies;
    logic [31:0]                               ticks_wide;
    logic                                      ticks_over;
    logic [FILTER_COUNT_BITS-1:0]              load_value;
    logic [FILTER_COUNT_BITS-1:0]              count_dec;
    logic                                      report;
    logic                                      level;

    // a new item enters whenever the result slot is free or being emptied
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign out_valid      = out_valid_reg;
    assign reported_level = reported_level_reg;

    // countdown load value: zero counts as one, saturate if the counter is narrow
    assign ticks_wide = 32'(filter_ticks_reg);
    always_comb
    begin
        if (FILTER_COUNT_BITS >= 32)
        begin
            ticks_over = 1'b0;
        end
        else
        begin
            ticks_over = |(ticks_wide >> FILTER_COUNT_BITS);
        end
        if (filter_ticks_reg == '0)
        begin
            load_value = COUNT_ONE;
        end
        else if (ticks_over)
        begin
            load_value = COUNT_MAX;
        end
        else
        begin
            load_value = ticks_wide[FILTER_COUNT_BITS-1:0];
        end
    end

    // edge detect against the previous sample
    assign rise = pin_level && !previous_sample_reg;
    assign fall = !pin_level && previous_sample_reg;

    always_comb
    begin
        case (trigger_mode_reg)
            edq_pkg::MODE_ANY:  qualifies = rise || fall;
            edq_pkg::MODE_RISE: qualifies = rise;
            edq_pkg::MODE_FALL: qualifies = fall;
            default:            qualifies = 1'b0;
        endcase
    end

    // countdown step, holds at zero
    assign count_dec = filter_count_reg - FILTER_COUNT_BITS'(filter_count_reg != '0);

    // level check when the countdown runs out, using the mode in force now
    always_comb
    begin
        case (trigger_mode_reg)
            edq_pkg::MODE_ANY:
            begin
                report = 1'b1;
                level  = captured_level_reg;
            end
            edq_pkg::MODE_RISE:
            begin
                report = pin_level;
                level  = 1'b1;
            end
            edq_pkg::MODE_FALL:
            begin
                report = !pin_level;
                level  = 1'b0;
            end
            default:
            begin
                report = 1'b0;
                level  = 1'b0;
            end
        endcase
    end

    // next state for one accepted item
    always_comb
    begin
        previous_sample_next = previous_sample_reg;
        captured_level_next  = captured_level_reg;
        filter_count_next    = filter_count_reg;
        filter_armed_next    = filter_armed_reg;
        out_valid_next       = out_valid_reg && !out_ready;
        reported_level_next  = reported_level_reg;
        if (accept)
        begin
            previous_sample_next = pin_level;
            if (qualifies)
            begin
                // qualifying edge restarts the countdown
                captured_level_next = pin_level;
                filter_count_next   = load_value;
                filter_armed_next   = 1'b1;
            end
            else if (filter_armed_reg)
            begin
                filter_count_next = count_dec;
                if (count_dec == '0)
                begin
                    filter_armed_next = 1'b0;
                    if (report)
                    begin
                        out_valid_next      = 1'b1;
                        reported_level_next = level ^ invert_reg;
                    end
                end
            end
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_mode_reg <= edq_pkg::MODE_ANY;
            invert_reg       <= 1'b0;
            filter_ticks_reg <= edq_pkg::FILTER_TICKS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                edq_pkg::CFG_TRIGGER_MODE: trigger_mode_reg <= cfg_data[1:0];
                edq_pkg::CFG_INVERT:       invert_reg       <= cfg_data[0];
                edq_pkg::CFG_FILTER_TICKS:
                    filter_ticks_reg <= cfg_data[edq_pkg::FILTER_TICKS_BITS-1:0];
                default: ;
            endcase
        end
    end

    // debounce state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_sample_reg <= 1'b0;
            captured_level_reg  <= 1'b0;
            filter_count_reg    <= '0;
            filter_armed_reg    <= 1'b0;
            out_valid_reg       <= 1'b0;
            reported_level_reg  <= 1'b0;
        end
        else
        begin
            previous_sample_reg <= previous_sample_next;
            captured_level_reg  <= captured_level_next;
            filter_count_reg    <= filter_count_next;
            filter_armed_reg    <= filter_armed_next;
            out_valid_reg       <= out_valid_next;
            reported_level_reg  <= reported_level_next;
        end
    end

endmodule

/* design/edq_checker.sv */
// edq_checker: port-level assertions for the edge-qualified input debouncer
// bound to edge_debounce_input_qualifier_core; no other dependencies
module edq_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_ready,
    input logic                                  out_valid,
    input logic                                  out_ready,
    input logic                                  reported_level,
    input logic                                  cfg_valid,
    input logic                                  cfg_ready
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(reported_level))
        else $error("result changed while stalled");

    // an empty result slot never blocks input
    a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result slot");

    // a new result item only follows an accepted item
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !$past(out_valid && !out_ready) |-> $past(in_valid && in_ready))
        else $error("result item without an accepted item");

    // configuration writes are never stalled
    a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind edge_debounce_input_qualifier_core edq_checker u_edq_checker (.*);

/* tb/edge_debounce_input_qualifier_core_tb.sv */
`timescale 1ns / 1ps
// edge_debounce_input_qualifier_core_tb: self-checking bench for the edge-qualified pin debouncer
// tracks edges and countdowns per pin sample to predict reported levels; needs edq_pkg and the core
module edge_debounce_input_qualifier_core_tb;

    // counter width of the instance, kept equal to the core's default
    localparam int unsigned CNT_BITS = 16;
    localparam longint unsigned CNT_MAX = (64'd1 << CNT_BITS) - 1;

    // mode code that qualifies no edge, and the register index nobody decodes
    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam logic [edq_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE = 2'd3;

    // cycles to let pass after the last result before touching a register
    localparam int SETTLE_CYCLES = 4;
    // length of the long output stall
    localparam int HOLD_CYCLES = 300;
    // cycles without any handshake before the run is abandoned
    localparam int STUCK_LIMIT = 3000;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                in_valid = 1'b0;
    logic                                in_ready;
    logic                                pin_level = 1'b0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic                                reported_level;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [edq_pkg::CFG_INDEX_BITS-1:0]  cfg_index = '0;
    logic [edq_pkg::CFG_DATA_BITS-1:0]   cfg_data = '0;

    // register copies as the core should hold them
    logic [1:0]                            cur_mode = edq_pkg::MODE_ANY;
    logic                                  cur_invert = 1'b0;
    logic [edq_pkg::FILTER_TICKS_BITS-1:0] cur_ticks = edq_pkg::FILTER_TICKS_RESET;

    // debounce state as the core should hold it
    logic                last_pin = 1'b0;
    logic                held_level = 1'b0;
    logic [CNT_BITS-1:0] countdown = '0;
    logic                counting = 1'b0;

    // reported levels still owed by the core, oldest first
    logic expected_levels[$];

    int errors = 0;
    int n_samples = 0;
    int n_reports = 0;
    int n_writes = 0;
    int holds_asked = 0;
    int holds_served = 0;
    int hold_left = 0;
    int stuck_cycles = 0;
    bit steady = 1'b0;

    edge_debounce_input_qualifier_core #(
        .FILTER_COUNT_BITS(CNT_BITS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .pin_level      (pin_level),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .reported_level (reported_level),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    // countdown reload: zero acts as one tick, too large saturates at the counter's top
    function automatic logic [CNT_BITS-1:0] load_count();
        longint unsigned v;
        v = cur_ticks;
        if (v == 0)
            v = 1;
        if (v > CNT_MAX)
            v = CNT_MAX;
        return v[CNT_BITS-1:0];
    endfunction

    // one pin sample: qualify the edge, run the countdown, queue a level if it fires
    task automatic debounce_step(input logic lvl);
        logic rise;
        logic fall;
        logic hit;
        logic fire;
        logic lvl_out;
        rise = lvl && !last_pin;
        fall = !lvl && last_pin;
        case (cur_mode)
            edq_pkg::MODE_ANY:  hit = rise || fall;
            edq_pkg::MODE_RISE: hit = rise;
            edq_pkg::MODE_FALL: hit = fall;
            default:            hit = 1'b0;
        endcase
        last_pin = lvl;
        n_samples++;
        if (hit)
        begin
            held_level = lvl;
            countdown = load_count();
            counting = 1'b1;
        end
        else if (counting)
        begin
            if (countdown != 0)
                countdown = countdown - 1'b1;
            if (countdown == 0)
            begin
                // the check uses the mode in force right now, not the one that armed it
                counting = 1'b0;
                fire = 1'b0;
                lvl_out = 1'b0;
                case (cur_mode)
                    edq_pkg::MODE_ANY:
                    begin
                        fire = 1'b1;
                        lvl_out = held_level;
                    end
                    edq_pkg::MODE_RISE:
                        if (lvl)
                        begin
                            fire = 1'b1;
                            lvl_out = 1'b1;
                        end
                    edq_pkg::MODE_FALL:
                        if (!lvl)
                        begin
                            fire = 1'b1;
                            lvl_out = 1'b0;
                        end
                    default: ;
                endcase
                if (fire)
                    expected_levels.push_back(lvl_out ^ cur_invert);
            end
        end
    endtask

    task automatic apply_write(input logic [edq_pkg::CFG_INDEX_BITS-1:0] idx,
                               input logic [edq_pkg::CFG_DATA_BITS-1:0] data);
        n_writes++;
        case (idx)
            edq_pkg::CFG_TRIGGER_MODE: cur_mode = data[1:0];
            edq_pkg::CFG_INVERT:       cur_invert = data[0];
            edq_pkg::CFG_FILTER_TICKS: cur_ticks = data[edq_pkg::FILTER_TICKS_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic check_result(input logic got);
        logic want;
        if (expected_levels.size() == 0)
            report_mismatch($sformatf("reported_level %0b with nothing owed", got));
        else
        begin
            want = expected_levels.pop_front();
            n_reports++;
            if (got !== want)
                report_mismatch($sformatf("reported_level %0b, want %0b", got, want));
        end
    endtask

    // all handshakes are sampled at the edge, before any nonblocking update lands
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                apply_write(cfg_index, cfg_data);
            // a result seen here always belongs to an earlier item
            if (out_valid && out_ready)
                check_result(reported_level);
            if (in_valid && in_ready)
                debounce_step(pin_level);
        end
    end

    // receiver: random stalls, a long hold-off on request, none while steady
    always @(posedge clk)
    begin
        if (holds_served != holds_asked)
        begin
            holds_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (!steady && $urandom_range(99) < 10)
            out_ready <= 1'b0;
        else
            out_ready <= 1'b1;
    end

    // watchdog on cycles with no handshake on any channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stuck_cycles = 0;
        else
        begin
            stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", STUCK_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // offer one pin sample and wait for it to be taken; valid stays up for the next item
    task automatic offer_sample(input logic lvl);
        if (!steady && $urandom_range(99) < 10)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pin_level <= lvl;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // stop sending, wait for every owed level, then let the core settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_levels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [edq_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [edq_pkg::CFG_DATA_BITS-1:0] data);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mostly bounce bursts followed by a stable level that may or may not last long enough to pass
    // the filter, the rest plain noise
    task automatic drive_presses(input int n_items);
        int sent;
        int bounce;
        int hold_len;
        logic lvl;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 70)
            begin
                bounce = $urandom_range(0, 6);
                repeat (bounce)
                begin
                    offer_sample(1'($urandom_range(0, 1)));
                    sent++;
                end
                lvl = 1'($urandom_range(0, 1));
                if (cur_ticks <= 64)
                    hold_len = $urandom_range(0, int'(cur_ticks) + 3);
                else
                    hold_len = $urandom_range(1, 40);
                repeat (hold_len)
                begin
                    offer_sample(lvl);
                    sent++;
                end
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                begin
                    offer_sample(1'($urandom_range(0, 1)));
                    sent++;
                end
            end
        end
    endtask

    task automatic offer_list(input logic lvls[$]);
        foreach (lvls[i])
            offer_sample(lvls[i]);
    endtask

    // out of reset: any edge, no inversion, fifty-tick filter
    task automatic test_power_up_defaults();
        drive_presses(150);
    endtask

    task automatic test_directed();
        // any edge with zero filter time acting as one tick; an edge on the
        // tick where the count would run out restarts it
        write_reg(edq_pkg::CFG_TRIGGER_MODE, {14'd0, edq_pkg::MODE_ANY});
        write_reg(edq_pkg::CFG_INVERT, 16'd0);
        write_reg(edq_pkg::CFG_FILTER_TICKS, 16'd0);
        offer_list('{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0});

        // rising only, inverted; pin low at the check gives nothing
        write_reg(edq_pkg::CFG_TRIGGER_MODE, {14'd0, edq_pkg::MODE_RISE});
        write_reg(edq_pkg::CFG_INVERT, 16'd1);
        write_reg(edq_pkg::CFG_FILTER_TICKS, 16'd2);
        offer_list('{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1});

        // falling only, no inversion; pin high at the check gives nothing
        write_reg(edq_pkg::CFG_TRIGGER_MODE, {14'd0, edq_pkg::MODE_FALL});
        write_reg(edq_pkg::CFG_INVERT, 16'd0);
        write_reg(edq_pkg::CFG_FILTER_TICKS, 16'd1);
        offer_list('{1'b0, 1'b1, 1'b0, 1'b0});

        // mode and invert switched while the countdown runs
        write_reg(edq_pkg::CFG_FILTER_TICKS, 16'd3);
        offer_list('{1'b1, 1'b0});
        write_reg(edq_pkg::CFG_TRIGGER_MODE, {14'd0, edq_pkg::MODE_ANY});
        write_reg(edq_pkg::CFG_INVERT, 16'hfffe | 16'd1);
        offer_list('{1'b0, 1'b0, 1'b0});

        // unused mode: the countdown runs out with no report, no edge qualifies
        write_reg(edq_pkg::CFG_FILTER_TICKS, 16'd2);
        offer_list('{1'b1});
        write_reg(edq_pkg::CFG_TRIGGER_MODE, 16'hfffc | {14'd0, MODE_NONE});
        offer_list('{1'b1, 1'b1, 1'b0, 1'b1});

        // largest filter time, armed but far from expiring; spare index ignored
        write_reg(edq_pkg::CFG_FILTER_TICKS, 16'hffff);
        write_reg(edq_pkg::CFG_TRIGGER_MODE, {14'd0, edq_pkg::MODE_ANY});
        offer_list('{1'b0, 1'b1, 1'b0});
        write_reg(CFG_SPARE, 16'h5a5a);
    endtask

    // long output stall with a result every other sample, so the input backs up
    task automatic test_backpressure();
        write_reg(edq_pkg::CFG_TRIGGER_MODE, {14'd0, edq_pkg::MODE_ANY});
        write_reg(edq_pkg::CFG_INVERT, {15'd0, 1'($urandom_range(0, 1))});
        write_reg(edq_pkg::CFG_FILTER_TICKS, 16'd1);
        holds_asked++;
        repeat (10)
            offer_list('{1'b1, 1'b1, 1'b0, 1'b0});
        drain();
    endtask

    // no idling on either side for a while
    task automatic test_steady_stream();
        write_reg(edq_pkg::CFG_FILTER_TICKS, 16'd3);
        steady = 1'b1;
        drive_presses(150);
        drain();
        steady = 1'b0;
    endtask

    task automatic test_random_settings(input int phases, input int per_phase);
        int r;
        logic [1:0] mode;
        logic [15:0] ticks;
        for (int p = 0; p < phases; p++)
        begin
            r = $urandom_range(99);
            if (r < 30)
                mode = edq_pkg::MODE_ANY;
            else if (r < 60)
                mode = edq_pkg::MODE_RISE;
            else if (r < 90)
                mode = edq_pkg::MODE_FALL;
            else
                mode = MODE_NONE;
            r = $urandom_range(99);
            if (r < 50)
                ticks = 16'($urandom_range(1, 4));
            else if (r < 80)
                ticks = 16'($urandom_range(5, 16));
            else if (r < 90)
                ticks = 16'($urandom_range(17, 60));
            else if (r < 95)
                ticks = 16'd0;
            else
                ticks = 16'($urandom);
            // upper data bits are don't-care for the narrow registers
            write_reg(edq_pkg::CFG_TRIGGER_MODE, (16'($urandom) & 16'hfffc) | {14'd0, mode});
            write_reg(edq_pkg::CFG_INVERT, {15'($urandom), 1'($urandom_range(0, 1))});
            write_reg(edq_pkg::CFG_FILTER_TICKS, ticks);
            drive_presses(per_phase);
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_up_defaults();
        test_directed();
        test_backpressure();
        test_steady_stream();
        test_random_settings(12, 100);

        // everything sent: wait for the last owed levels, then a short tail
        drain();
        repeat (10) @(posedge clk);
        if (expected_levels.size() != 0)
            report_mismatch($sformatf("%0d levels never reported", expected_levels.size()));

        $display("covered %0d pin samples and %0d reported levels over %0d register writes,",
                 n_samples, n_reports, n_writes);
        $display("all trigger modes, both polarities, filter times 0 to 65535, %0d long stall(s)",
                 holds_served);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
